// ===== rtl/core/wtsp_pkg.sv =====
package wtsp_pkg;

  localparam int unsigned CoefCount     = 12;
  localparam int unsigned CoordW        = 32;
  localparam int unsigned SizeW         = 14;
  localparam int unsigned PixW          = 16;
  localparam int unsigned ProdW         = 64;
  localparam int unsigned ProdShift     = 12;
  localparam int unsigned DotW          = 54;
  localparam int unsigned DivSteps      = 24;
  localparam int unsigned DivShift      = 8;
  localparam int unsigned DivRW         = DotW - 1 + DivShift;
  localparam int unsigned RatioW        = DivSteps + 1;
  localparam int unsigned OffW          = RatioW + 2;
  localparam int unsigned PixelFracBits = 17;
  localparam int unsigned PixProdW      = SizeW + 1 + OffW;
  localparam int          MarginPx      = 100;
  localparam int unsigned CfgIdxW       = 2;

  localparam logic signed [DotW-1:0] WMinQ24 = DotW'(16777);
  localparam logic signed [OffW-1:0] PixOne  = OffW'(65536);
  localparam logic signed [PixProdW-1:0] VisLo =
    PixProdW'(-(MarginPx * (1 << PixelFracBits)));
  localparam logic signed [PixW-1:0] PixMax = 16'sh7fff;
  localparam logic signed [PixW-1:0] PixMin = 16'sh8000;

  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 2'd1;

  typedef enum logic {
    OpLoad    = 1'b0,
    OpProject = 1'b1
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [3:0]               coef_index;
    logic signed [CoordW-1:0] coef_value;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } item_in_t;

  typedef struct packed {
    logic signed [PixW-1:0] screen_x;
    logic signed [PixW-1:0] screen_y;
    logic                   visible;
  } item_out_t;

  typedef struct packed {
    logic signed [DotW-1:0] w;
    logic signed [DotW-1:0] cx;
    logic signed [DotW-1:0] cy;
  } clip_t;

  typedef struct packed {
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
  } screen_t;

endpackage

// ===== rtl/core/world_to_screen_projection.sv =====
// Channel | Direction | Handshake                    | Payload
// in      | input     | in_valid_i / in_stall_o      | in_data_i  (item_in_t)
// out     | output    | out_valid_o / out_stall_i    | out_data_o (item_out_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while no stall holds the flow; a project item's result
// passes through 2 product/sum stages, the queue, an operand stage, 24 divider stages,
// multiply and output.
// Load items update the coefficient store on acceptance and produce no result.
// Reset clears coefficients to zero and sets the screen to 1920 x 1080.
// An output stall freezes the back pipeline; the front keeps going until the queue fills.
module world_to_screen_projection #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  wtsp_pkg::item_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wtsp_pkg::item_out_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wtsp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wtsp_pkg::SizeW-1:0]    cfg_data_i
);

  wtsp_pkg::screen_t screen_q;
  wtsp_pkg::clip_t   fq_data, qb_data;
  logic              fq_valid, fq_stall, qb_valid, qb_stall;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_q.width  <= wtsp_pkg::SizeW'(1920);
      screen_q.height <= wtsp_pkg::SizeW'(1080);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == wtsp_pkg::CfgScreenWidth) begin
        screen_q.width <= cfg_data_i;
      end else if (cfg_index_i == wtsp_pkg::CfgScreenHeight) begin
        screen_q.height <= cfg_data_i;
      end
    end
  end

  wtsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (fq_valid),
    .q_stall_i  (fq_stall),
    .q_data_o   (fq_data)
  );

  wtsp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_stall_o  (fq_stall),
    .in_data_i   (fq_data),
    .out_valid_o (qb_valid),
    .out_stall_i (qb_stall),
    .out_data_o  (qb_data)
  );

  wtsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .screen_i    (screen_q),
    .q_valid_i   (qb_valid),
    .q_stall_o   (qb_stall),
    .q_data_i    (qb_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/wtsp_front.sv =====
module wtsp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wtsp_pkg::item_in_t in_data_i,
  output logic              q_valid_o,
  input  logic              q_stall_i,
  output wtsp_pkg::clip_t   q_data_o
);

  logic signed [wtsp_pkg::CoordW-1:0] coef_q [wtsp_pkg::CoefCount];
  logic signed [wtsp_pkg::CoordW-1:0] pt [3];
  logic signed [wtsp_pkg::ProdW-1:0]  prod_q [9];
  logic signed [wtsp_pkg::CoordW-1:0] off_q [3];
  logic signed [wtsp_pkg::DotW-1:0]   dot [3];
  logic        v1_q, v2_q;
  logic        ready1, ready2, accept;
  wtsp_pkg::clip_t clip_q;

  assign pt[0] = in_data_i.point_x;
  assign pt[1] = in_data_i.point_y;
  assign pt[2] = in_data_i.point_z;

  assign ready2     = !v2_q || !q_stall_i;
  assign ready1     = !v1_q || ready2;
  assign in_stall_o = !ready1;
  assign accept     = in_valid_i && ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wtsp_pkg::CoefCount; i++) begin
        coef_q[i] <= '0;
      end
    end else if (accept && in_data_i.op == wtsp_pkg::OpLoad &&
                 in_data_i.coef_index < 4'(wtsp_pkg::CoefCount)) begin
      coef_q[in_data_i.coef_index] <= in_data_i.coef_value;
    end
  end

  // Stage 1: nine products; row 2 of the store holds the w row
  always_ff @(posedge clk_i) begin
    if (ready1) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r*3+c] <= coef_q[r*4+c] * pt[c];
        end
        off_q[r] <= coef_q[r*4+3];
      end
    end
  end

  // Stage 2: floor each product to Q.24 and add the offset
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dot[r] = wtsp_pkg::DotW'(prod_q[r*3]   >>> wtsp_pkg::ProdShift)
             + wtsp_pkg::DotW'(prod_q[r*3+1] >>> wtsp_pkg::ProdShift)
             + wtsp_pkg::DotW'(prod_q[r*3+2] >>> wtsp_pkg::ProdShift)
             + wtsp_pkg::DotW'(off_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2) begin
      clip_q.cx <= dot[0];
      clip_q.cy <= dot[1];
      clip_q.w  <= dot[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= accept && in_data_i.op == wtsp_pkg::OpProject;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
    end
  end

  assign q_valid_o = v2_q;
  assign q_data_o  = clip_q;

  a_stage2_from_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !$past(v2_q)) |-> $past(v1_q))
    else $error("stage 2 filled without stage 1");

endmodule

// ===== rtl/core/wtsp_queue.sv =====
module wtsp_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  wtsp_pkg::clip_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output wtsp_pkg::clip_t out_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wtsp_pkg::clip_t  mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign in_stall_o  = count_q == CntW'(Depth);
  assign out_valid_o = count_q != '0;
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count lost a push");

endmodule

// ===== rtl/core/wtsp_back.sv =====
module wtsp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wtsp_pkg::screen_t  screen_i,
  input  logic               q_valid_i,
  output logic               q_stall_o,
  input  wtsp_pkg::clip_t    q_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wtsp_pkg::item_out_t out_data_o
);

  localparam int unsigned N = wtsp_pkg::DivSteps;
  localparam int unsigned RW = wtsp_pkg::DivRW;

  logic              en;
  logic              v_q      [N+1];
  logic              behind_q [N+1];
  logic              sx_q     [N+1];
  logic              sy_q     [N+1];
  logic [RW-1:0]     dd_q     [N+1];
  logic [RW-1:0]     rx_q     [N+1];
  logic [RW-1:0]     ry_q     [N+1];
  logic              satx_q   [1:N];
  logic              saty_q   [1:N];
  logic [N-1:0]      qx_q     [1:N];
  logic [N-1:0]      qy_q     [1:N];

  logic [wtsp_pkg::DotW-1:0] magx, magy;

  logic                                 vm_q, behind_m_q;
  logic signed [wtsp_pkg::PixProdW-1:0] x17_q, y17_q;
  logic [wtsp_pkg::RatioW-1:0]          ratx, raty;
  logic signed [wtsp_pkg::OffW-1:0]     offx, offy;

  logic                 vo_q;
  wtsp_pkg::item_out_t  out_q;

  assign en        = !(vo_q && out_stall_i);
  assign q_stall_o = !en;

  assign magx = q_data_i.cx[wtsp_pkg::DotW-1] ? wtsp_pkg::DotW'(-q_data_i.cx) : q_data_i.cx;
  assign magy = q_data_i.cy[wtsp_pkg::DotW-1] ? wtsp_pkg::DotW'(-q_data_i.cy) : q_data_i.cy;

  // Stage 0: magnitudes, signs, divisor scaled by 2^8
  always_ff @(posedge clk_i) begin
    if (en) begin
      behind_q[0] <= q_data_i.w < wtsp_pkg::WMinQ24;
      sx_q[0]     <= q_data_i.cx[wtsp_pkg::DotW-1];
      sy_q[0]     <= q_data_i.cy[wtsp_pkg::DotW-1];
      dd_q[0]     <= {q_data_i.w[wtsp_pkg::DotW-2:0], wtsp_pkg::DivShift'(0)};
      rx_q[0]     <= RW'(magx);
      ry_q[0]     <= RW'(magy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= q_valid_i;
    end
  end

  // One restoring quotient bit per stage
  for (genvar s = 1; s <= N; s++) begin : g_step
    logic [RW:0]   r2x, r2y;
    logic          gex, gey;
    logic          satx_in, saty_in;
    logic [N-1:0]  qx_in, qy_in;

    assign r2x = {rx_q[s-1], 1'b0};
    assign r2y = {ry_q[s-1], 1'b0};
    assign gex = r2x >= {1'b0, dd_q[s-1]};
    assign gey = r2y >= {1'b0, dd_q[s-1]};

    if (s == 1) begin : g_first
      assign satx_in = rx_q[0] >= dd_q[0];
      assign saty_in = ry_q[0] >= dd_q[0];
      assign qx_in   = '0;
      assign qy_in   = '0;
    end else begin : g_next
      assign satx_in = satx_q[s-1];
      assign saty_in = saty_q[s-1];
      assign qx_in   = qx_q[s-1];
      assign qy_in   = qy_q[s-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rx_q[s]     <= gex ? RW'(r2x - {1'b0, dd_q[s-1]}) : r2x[RW-1:0];
        ry_q[s]     <= gey ? RW'(r2y - {1'b0, dd_q[s-1]}) : r2y[RW-1:0];
        qx_q[s]     <= {qx_in[N-2:0], gex};
        qy_q[s]     <= {qy_in[N-2:0], gey};
        satx_q[s]   <= satx_in;
        saty_q[s]   <= saty_in;
        dd_q[s]     <= dd_q[s-1];
        sx_q[s]     <= sx_q[s-1];
        sy_q[s]     <= sy_q[s-1];
        behind_q[s] <= behind_q[s-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  // Viewport multiply
  assign ratx = satx_q[N] ? wtsp_pkg::RatioW'(1 << N) : {1'b0, qx_q[N]};
  assign raty = saty_q[N] ? wtsp_pkg::RatioW'(1 << N) : {1'b0, qy_q[N]};
  assign offx = sx_q[N] ? wtsp_pkg::PixOne - $signed({2'b0, ratx})
                        : wtsp_pkg::PixOne + $signed({2'b0, ratx});
  assign offy = sy_q[N] ? wtsp_pkg::PixOne + $signed({2'b0, raty})
                        : wtsp_pkg::PixOne - $signed({2'b0, raty});

  always_ff @(posedge clk_i) begin
    if (en) begin
      x17_q      <= $signed({1'b0, screen_i.width}) * offx;
      y17_q      <= $signed({1'b0, screen_i.height}) * offy;
      behind_m_q <= behind_q[N];
    end
  end

  // Output stage: floor to pixels, saturate, margin test
  logic signed [wtsp_pkg::PixProdW-wtsp_pkg::PixelFracBits-1:0] pixx, pixy;
  logic [wtsp_pkg::SizeW:0]              wm, hm;
  logic signed [wtsp_pkg::PixProdW-1:0]  xhi, yhi;
  logic signed [wtsp_pkg::PixW-1:0]      satx_px, saty_px;
  logic                                  vis;

  assign pixx = x17_q[wtsp_pkg::PixProdW-1:wtsp_pkg::PixelFracBits];
  assign pixy = y17_q[wtsp_pkg::PixProdW-1:wtsp_pkg::PixelFracBits];
  assign wm   = {1'b0, screen_i.width}  + (wtsp_pkg::SizeW+1)'(wtsp_pkg::MarginPx);
  assign hm   = {1'b0, screen_i.height} + (wtsp_pkg::SizeW+1)'(wtsp_pkg::MarginPx);
  assign xhi  = $signed(wtsp_pkg::PixProdW'({wm, wtsp_pkg::PixelFracBits'(0)}));
  assign yhi  = $signed(wtsp_pkg::PixProdW'({hm, wtsp_pkg::PixelFracBits'(0)}));

  always_comb begin
    priority if (pixx > $signed(wtsp_pkg::PixMax)) begin
      satx_px = wtsp_pkg::PixMax;
    end else if (pixx < $signed(wtsp_pkg::PixMin)) begin
      satx_px = wtsp_pkg::PixMin;
    end else begin
      satx_px = wtsp_pkg::PixW'(pixx);
    end
    priority if (pixy > $signed(wtsp_pkg::PixMax)) begin
      saty_px = wtsp_pkg::PixMax;
    end else if (pixy < $signed(wtsp_pkg::PixMin)) begin
      saty_px = wtsp_pkg::PixMin;
    end else begin
      saty_px = wtsp_pkg::PixW'(pixy);
    end
    vis = x17_q >= wtsp_pkg::VisLo && x17_q <= xhi &&
          y17_q >= wtsp_pkg::VisLo && y17_q <= yhi;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (behind_m_q) begin
        out_q <= '0;
      end else begin
        out_q.screen_x <= satx_px;
        out_q.screen_y <= saty_px;
        out_q.visible  <= vis;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      vm_q <= v_q[N];
      vo_q <= vm_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  a_div_to_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[N] && en) |=> vm_q)
    else $error("divider output dropped");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && out_stall_i) |=> (vo_q && $stable(vm_q) && $stable(v_q[0])))
    else $error("back pipeline moved while stalled");

endmodule
